// ===== rtl/ukrt_pkg.sv =====
// Shared types, sizes and codes of the unique-key record table.
package ukrt_pkg;

    localparam int ENTRIES   = 16;
    localparam int WORD_BITS = 64;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int FIELD_W   = 64;
    localparam int SLOT_W    = 4;
    localparam int LIVE_W    = 5;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        t_word key;
        t_word name;
        t_word phone;
        t_word address;
    } t_rec;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_UPDATE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        FLD_NONE    = 2'd0,
        FLD_NAME    = 2'd1,
        FLD_PHONE   = 2'd2,
        FLD_ADDRESS = 2'd3
    } t_field;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_DUP       = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [FIELD_W-1:0] key;
        logic [FIELD_W-1:0] name_word;
        logic [FIELD_W-1:0] phone_word;
        logic [FIELD_W-1:0] address_word;
        t_field             field_select;
    } t_in_word;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot_index;
        logic [LIVE_W-1:0]  live_count;
        logic [FIELD_W-1:0] rec_key;
        logic [FIELD_W-1:0] rec_name;
        logic [FIELD_W-1:0] rec_phone;
        logic [FIELD_W-1:0] rec_address;
    } t_out_word;

    // Ring control: shift enable and the record entering the tail cell.
    typedef struct packed {
        logic shift;
        t_rec tail;
    } t_ring_ctl;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_FIX  = 4'b0100,
        ST_PUSH = 4'b1000
    } t_state;

endpackage

// ===== rtl/unique_key_record_table_unit.sv =====
// Top level of the unique-key record table: a rotating ring of record cells and its sequencer.
//
// The table holds up to 16 records in a ring of cells that, while a command is scanned,
// rotates one place per cycle past a single compare point, so every command takes one full
// revolution of the ring. Insert, lookup, update and a remove of an absent key go from
// acceptance through the scan of all 16 cells to the push state, which loads the result
// word once the output register is free; a remove that finds its key takes a second
// revolution to move the last live record into the freed slot before the push state.
// The result word sits in an output register, and a new word is accepted while it waits
// to be taken. Table contents are not cleared at reset; only the live count is.
module unique_key_record_table_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ukrt_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ukrt_pkg::t_out_word o_out_data
);
    import ukrt_pkg::*;

    t_rec      w_cell_q [ENTRIES];
    t_rec      w_cell_d [ENTRIES];
    t_ring_ctl w_ctl;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == ENTRIES - 1) begin : g_tail
            assign w_cell_d[g] = w_ctl.tail;
        end else begin : g_body
            assign w_cell_d[g] = w_cell_q[g+1];
        end

        ukrt_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_ctl.shift),
            .i_rec   (w_cell_d[g]),
            .o_rec   (w_cell_q[g])
        );
    end

    ukrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_head      (w_cell_q[0]),
        .o_ctl       (w_ctl)
    );

endmodule

// ===== rtl/ukrt_cell.sv =====
// One record cell of the rotating table ring.
module ukrt_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  ukrt_pkg::t_rec i_rec,
    output ukrt_pkg::t_rec o_rec
);
    import ukrt_pkg::*;

    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

// ===== rtl/ukrt_ctrl.sv =====
// Sequencer that scans the record ring, applies commands and holds the result word.
module ukrt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ukrt_pkg::t_in_word  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ukrt_pkg::t_out_word o_out_data,
    input  ukrt_pkg::t_rec      i_head,
    output ukrt_pkg::t_ring_ctl o_ctl
);
    import ukrt_pkg::*;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_step, n_step;
    logic [CNT_W-1:0]   r_count, n_count;
    t_cmd               r_cmd, n_cmd;
    t_field             r_sel, n_sel;
    t_rec               r_new, n_new;
    logic               r_found, n_found;
    logic               r_ins, n_ins;
    logic [IDX_W-1:0]   r_idx, n_idx;
    t_rec               r_rec, n_rec;
    t_rec               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    t_out_word          r_out, n_out;

    logic               live;
    logic               hit;
    logic               step_last;
    logic               step_is_count;
    logic               step_is_tail;
    logic               push_load;
    t_rec               upd_rec;
    t_out_word          res;
    logic [CNT_W-1:0]   res_count;

    assign live          = CNT_W'(r_step) < r_count;
    assign hit           = live && (i_head.key == r_new.key) && !r_found;
    assign step_last     = r_step == IDX_W'(ENTRIES - 1);
    assign step_is_count = CNT_W'(r_step) == r_count;
    assign step_is_tail  = CNT_W'(r_step) == (r_count - CNT_W'(1));
    assign push_load     = (r_state == ST_PUSH) && (!r_out_valid || i_out_ready);

    always_comb begin
        upd_rec = i_head;
        case (r_sel)
            FLD_NAME:    upd_rec.name    = r_new.name;
            FLD_PHONE:   upd_rec.phone   = r_new.phone;
            FLD_ADDRESS: upd_rec.address = r_new.address;
            default:     upd_rec = i_head;
        endcase
    end

    always_comb begin
        res           = '0;
        res_count     = r_count;
        res.status    = STAT_OK;
        if (r_cmd == CMD_INSERT) begin
            if (r_found) begin
                res.status = STAT_DUP;
            end else if (r_ins) begin
                res_count = r_count + CNT_W'(1);
            end else begin
                res.status = STAT_FULL;
            end
        end else if (!r_found) begin
            res.status = STAT_NOT_FOUND;
        end else if (r_cmd == CMD_REMOVE) begin
            res_count = r_count - CNT_W'(1);
        end
        if (r_found || (r_cmd == CMD_INSERT && r_ins)) begin
            res.slot_index  = SLOT_W'(r_idx);
            res.rec_key     = FIELD_W'(r_rec.key);
            res.rec_name    = FIELD_W'(r_rec.name);
            res.rec_phone   = FIELD_W'(r_rec.phone);
            res.rec_address = FIELD_W'(r_rec.address);
        end
        res.live_count = LIVE_W'(res_count);
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_sel       = r_sel;
        n_new       = r_new;
        n_found     = r_found;
        n_ins       = r_ins;
        n_idx       = r_idx;
        n_rec       = r_rec;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_ctl.shift = 1'b0;
        o_ctl.tail  = i_head;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd         = i_in_data.cmd;
                    n_sel         = i_in_data.field_select;
                    n_new.key     = WORD_BITS'(i_in_data.key);
                    n_new.name    = WORD_BITS'(i_in_data.name_word);
                    n_new.phone   = WORD_BITS'(i_in_data.phone_word);
                    n_new.address = WORD_BITS'(i_in_data.address_word);
                    n_step        = '0;
                    n_found       = 1'b0;
                    n_ins         = 1'b0;
                    n_idx         = '0;
                    n_state       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_ctl.shift = 1'b1;
                n_step      = r_step + IDX_W'(1);
                if (hit) begin
                    n_found = 1'b1;
                    n_idx   = r_step;
                    n_rec   = i_head;
                end
                case (r_cmd)
                    CMD_INSERT: begin
                        if (step_is_count && !r_found) begin
                            o_ctl.tail = r_new;
                            n_rec      = r_new;
                            n_idx      = r_step;
                            n_ins      = 1'b1;
                        end
                    end
                    CMD_REMOVE: begin
                        if (step_is_tail) begin
                            n_last = i_head;
                        end
                    end
                    CMD_UPDATE: begin
                        if (hit) begin
                            o_ctl.tail = upd_rec;
                            n_rec      = upd_rec;
                        end
                    end
                    default: begin
                    end
                endcase
                if (step_last) begin
                    n_state = (r_cmd == CMD_REMOVE && n_found) ? ST_FIX : ST_PUSH;
                end
            end
            ST_FIX: begin
                o_ctl.shift = 1'b1;
                n_step      = r_step + IDX_W'(1);
                if (r_step == r_idx) begin
                    o_ctl.tail = r_last;
                end
                if (step_last) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (push_load) begin
                    n_out       = res;
                    n_out_valid = 1'b1;
                    n_count     = res_count;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_ins       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_found     <= n_found;
            r_ins       <= n_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_sel  <= n_sel;
        r_new  <= n_new;
        r_idx  <= n_idx;
        r_rec  <= n_rec;
        r_last <= n_last;
        r_out  <= n_out;
    end

    assign o_in_ready  = r_state == ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_pass_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && step_last) |=> (r_state == ST_FIX || r_state == ST_PUSH))
        else $error("scan pass did not end after a full revolution");

    a_push_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_load |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result word not loaded from push state");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !push_load |=> $stable(r_count))
        else $error("entry count changed outside result load");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_load |=> (r_count == $past(r_count)
                       || r_count == $past(r_count) + CNT_W'(1)
                       || r_count == $past(r_count) - CNT_W'(1)))
        else $error("entry count moved by more than one");

endmodule

// ===== bench/tb_unique_key_record_table_unit.sv =====
// Self-checking testbench for the unique-key record table unit, with random traffic and stalls.
module tb_unique_key_record_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ukrt_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int LONG_HOLD    = 600;
    localparam int SETTLE       = 60;
    localparam int RANDOM_ITEMS = 1100;
    localparam int POOL_SIZE    = 20;
    localparam int SHOWN_ERRORS = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_word  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_word o_out_data;

    t_word     table_key     [ENTRIES];
    t_word     table_name    [ENTRIES];
    t_word     table_phone   [ENTRIES];
    t_word     table_address [ENTRIES];
    int        table_live;
    t_out_word pending_results[$];
    t_word     key_pool[POOL_SIZE];
    int        fail_count;
    int        cycle_count;
    int        random_sent;
    bit        no_idle;
    bit        hold_request;

    unique_key_record_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_word rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Applies one command to the shadow table and returns the word the block should produce.
    function automatic t_out_word apply_table_command(t_in_word w);
        t_out_word r;
        t_word     k;
        int        hit;
        int        last;
        r   = '0;
        k   = w.key;
        hit = -1;
        for (int i = 0; i < table_live; i++) begin
            if (hit < 0 && table_key[i] == k) begin
                hit = i;
            end
        end
        r.status = STAT_OK;
        if (w.cmd == CMD_INSERT) begin
            if (hit >= 0) begin
                r.status = STAT_DUP;
            end else if (table_live >= ENTRIES) begin
                r.status = STAT_FULL;
            end else begin
                hit                = table_live;
                table_key[hit]     = k;
                table_name[hit]    = w.name_word;
                table_phone[hit]   = w.phone_word;
                table_address[hit] = w.address_word;
                table_live++;
            end
        end else if (hit < 0) begin
            r.status = STAT_NOT_FOUND;
        end else if (w.cmd == CMD_UPDATE) begin
            case (w.field_select)
                FLD_NAME:    table_name[hit]    = w.name_word;
                FLD_PHONE:   table_phone[hit]   = w.phone_word;
                FLD_ADDRESS: table_address[hit] = w.address_word;
                default: ;
            endcase
        end
        if (r.status == STAT_OK || r.status == STAT_DUP) begin
            r.slot_index  = SLOT_W'(hit);
            r.rec_key     = table_key[hit];
            r.rec_name    = table_name[hit];
            r.rec_phone   = table_phone[hit];
            r.rec_address = table_address[hit];
        end
        if (w.cmd == CMD_REMOVE && r.status == STAT_OK) begin
            last               = table_live - 1;
            table_key[hit]     = table_key[last];
            table_name[hit]    = table_name[last];
            table_phone[hit]   = table_phone[last];
            table_address[hit] = table_address[last];
            table_live         = last;
        end
        r.live_count = LIVE_W'(table_live);
        return r;
    endfunction

    function automatic t_in_word make_word(t_cmd c, t_word k, t_field f);
        t_in_word w;
        w.cmd          = c;
        w.key          = k;
        w.name_word    = rand_word();
        w.phone_word   = rand_word();
        w.address_word = rand_word();
        w.field_select = f;
        return w;
    endfunction

    function automatic void refresh_key_pool();
        t_word base;
        base = rand_word();
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i < POOL_SIZE / 2) begin
                key_pool[i] = rand_word();
            end else begin
                key_pool[i] = base ^ (t_word'(1) << $urandom_range(0, WORD_BITS - 1));
            end
        end
        key_pool[POOL_SIZE - 1] = base;
    endfunction

    // Keys come mostly from the live table or the pool, so that hits and duplicates are common.
    function automatic t_in_word random_word(int insert_pct, int remove_pct);
        t_in_word w;
        int       r;
        int       src;
        w   = make_word(CMD_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)],
                        t_field'($urandom_range(0, 3)));
        src = $urandom_range(0, 99);
        if (src < 10) begin
            w.key = rand_word();
            w.cmd = t_cmd'($urandom_range(0, 3));
            return w;
        end
        if (src < 50 && table_live > 0) begin
            w.key = table_key[$urandom_range(0, table_live - 1)];
        end
        r = $urandom_range(0, 99);
        if (r < insert_pct) begin
            w.cmd = CMD_INSERT;
        end else if (r < insert_pct + remove_pct) begin
            w.cmd = CMD_REMOVE;
        end else if ($urandom_range(0, 1) != 0) begin
            w.cmd = CMD_UPDATE;
        end else begin
            w.cmd = CMD_LOOKUP;
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(apply_table_command(w));
    endtask

    task automatic send_cmd(input t_cmd c, input t_word k, input t_field f);
        send_word(make_word(c, k, f));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic test_basic_ops();
        t_in_word w;
        t_word    other;
        other = rand_word();
        send_cmd(CMD_LOOKUP, '0, FLD_NONE);
        send_cmd(CMD_REMOVE, '0, FLD_NAME);
        send_cmd(CMD_UPDATE, '0, FLD_PHONE);
        w     = '0;
        w.cmd = CMD_INSERT;
        send_word(w);
        w     = '1;
        w.cmd = CMD_INSERT;
        send_word(w);
        send_cmd(CMD_INSERT, '0, FLD_ADDRESS);
        send_cmd(CMD_LOOKUP, '1, FLD_NONE);
        send_cmd(CMD_UPDATE, '1, FLD_NAME);
        send_cmd(CMD_UPDATE, '1, FLD_PHONE);
        send_cmd(CMD_UPDATE, '1, FLD_ADDRESS);
        send_cmd(CMD_UPDATE, '1, FLD_NONE);
        send_cmd(CMD_INSERT, other, FLD_NONE);
        send_cmd(CMD_REMOVE, '0, FLD_NONE);
        send_cmd(CMD_LOOKUP, other, FLD_NONE);
        send_cmd(CMD_REMOVE, '1, FLD_NONE);
        send_cmd(CMD_LOOKUP, '1, FLD_NONE);
        send_cmd(CMD_UPDATE, other, FLD_NAME);
        send_cmd(CMD_REMOVE, other, FLD_NONE);
        send_cmd(CMD_REMOVE, other, FLD_NONE);
        wait_drained();
    endtask

    task automatic test_backpressure();
        no_idle      = 1'b1;
        hold_request = 1'b1;
        repeat (12) begin
            send_word(random_word(50, 10));
        end
        wait_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_random_rounds();
        int extra;
        int round;
        round = 0;
        while (random_sent < RANDOM_ITEMS) begin
            refresh_key_pool();
            no_idle = (round % 4 == 3);
            extra   = 0;
            while (extra < 4) begin
                send_word(random_word(80, 5));
                random_sent++;
                if (table_live == ENTRIES) begin
                    extra++;
                end
            end
            repeat (30) begin
                send_word(random_word(35, 30));
                random_sent++;
            end
            extra = 0;
            while (extra < 3) begin
                send_word(random_word(5, 80));
                random_sent++;
                if (table_live == 0) begin
                    extra++;
                end
            end
            wait_drained();
            round++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS) begin
                    $display("unexpected result word %h", o_out_data);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status
                        || o_out_data.slot_index !== want.slot_index
                        || o_out_data.live_count !== want.live_count
                        || o_out_data.rec_key !== want.rec_key
                        || o_out_data.rec_name !== want.rec_name
                        || o_out_data.rec_phone !== want.rec_phone
                        || o_out_data.rec_address !== want.rec_address) begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS) begin
                        $display("mismatch: expected st=%0d slot=%0d live=%0d rec=%h %h %h %h",
                                 want.status, want.slot_index, want.live_count, want.rec_key,
                                 want.rec_name, want.rec_phone, want.rec_address);
                        $display("          actual   st=%0d slot=%0d live=%0d rec=%h %h %h %h",
                                 o_out_data.status, o_out_data.slot_index,
                                 o_out_data.live_count, o_out_data.rec_key,
                                 o_out_data.rec_name, o_out_data.rec_phone,
                                 o_out_data.rec_address);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT) begin
            $display("unique_key_record_table_unit test failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        refresh_key_pool();
        test_basic_ops();
        test_backpressure();
        test_random_rounds();
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("unique_key_record_table_unit test passed");
        end else begin
            $display("unique_key_record_table_unit test failed");
        end
        $finish;
    end

endmodule
